/* rtl/utrg_pkg.sv */
package utrg_pkg;

	// Command codes carried in the request item.
	localparam logic [2:0] CMD_PUT    = 3'd0;
	localparam logic [2:0] CMD_GET    = 3'd1;
	localparam logic [2:0] CMD_SEND   = 3'd2;
	localparam logic [2:0] CMD_TXDONE = 3'd3;
	localparam logic [2:0] CMD_RXBYTE = 3'd4;

	// Status codes returned with each result.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TX_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RX_EMPTY = 2'd2;
	localparam logic [1:0] STATUS_TX_EMPTY = 2'd3;

	// Source of the result byte once the ring read returns.
	localparam logic [1:0] DSEL_ZERO = 2'd0;
	localparam logic [1:0] DSEL_TX   = 2'd1;
	localparam logic [1:0] DSEL_RX   = 2'd2;

	localparam logic [7:0] STOP_CHAR_RESET = 8'd10;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  data_out;
		logic        rx_overwrote;
		logic        radio_enable;
		logic        send_request;
		logic [15:0] stop_count;
		logic [3:0]  tx_fill;
		logic [3:0]  rx_fill;
	} rsp_t;

	// Result of one item before the ring read data is merged in.
	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  dsel;
		logic        rx_overwrote;
		logic        radio_enable;
		logic        send_request;
		logic [15:0] stop_count;
		logic [3:0]  tx_fill;
		logic [3:0]  rx_fill;
	} partial_t;

endpackage

/* rtl/utrg_ring_ram.sv */
module utrg_ring_ram #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/utrg_ctrl.sv */
module utrg_ctrl #(
	parameter int RING_DEPTH = 16,
	parameter int PTR_W      = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  utrg_pkg::req_t      req,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	output logic                tx_we,
	output logic [PTR_W-1:0]    tx_waddr,
	output logic                tx_re,
	output logic [PTR_W-1:0]    tx_raddr,
	output logic                rx_we,
	output logic [PTR_W-1:0]    rx_waddr,
	output logic                rx_re,
	output logic [PTR_W-1:0]    rx_raddr,
	output logic [7:0]          wdata,
	output utrg_pkg::partial_t  result
);

	// Fill arithmetic needs room for the depth and at least the four reported bits.
	localparam int CW = (PTR_W + 1 > 4) ? PTR_W + 1 : 4;
	localparam logic [PTR_W-1:0] LAST  = PTR_W'(RING_DEPTH - 1);
	localparam logic [CW-1:0]    DEPTH_C = CW'(RING_DEPTH);

	logic [PTR_W-1:0] tx_head_q, tx_tail_q, rx_head_q, rx_tail_q;
	logic [PTR_W-1:0] tx_head_d, tx_tail_d, rx_head_d, rx_tail_d;
	logic             radio_q, radio_d, request_q, request_d;
	logic [15:0]      stop_cnt_q, stop_cnt_d;
	logic [7:0]       stop_char_q;
	logic [1:0]       status;
	logic [1:0]       dsel;
	logic             overwrote;
	logic [CW-1:0]    tx_fill_w, rx_fill_w;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == LAST) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [CW-1:0] ring_fill(input logic [PTR_W-1:0] head,
		input logic [PTR_W-1:0] tail);
		logic [CW-1:0] h;
		logic [CW-1:0] t;
		h = CW'(head);
		t = CW'(tail);
		ring_fill = (h >= t) ? h - t : h + DEPTH_C - t;
	endfunction

	// Decode one item: pointer moves, flag updates and ring accesses.
	always_comb begin
		tx_head_d  = tx_head_q;
		tx_tail_d  = tx_tail_q;
		rx_head_d  = rx_head_q;
		rx_tail_d  = rx_tail_q;
		radio_d    = radio_q;
		request_d  = request_q;
		stop_cnt_d = stop_cnt_q;
		status     = utrg_pkg::STATUS_OK;
		dsel       = utrg_pkg::DSEL_ZERO;
		overwrote  = 1'b0;
		tx_we      = 1'b0;
		tx_re      = 1'b0;
		rx_we      = 1'b0;
		rx_re      = 1'b0;
		case (req.cmd)
			utrg_pkg::CMD_PUT: begin
				if (ring_next(tx_head_q) == tx_tail_q) begin
					status = utrg_pkg::STATUS_TX_FULL;
				end else begin
					tx_we     = accept;
					tx_head_d = ring_next(tx_head_q);
					radio_d   = 1'b1;
					request_d = 1'b1;
				end
			end
			utrg_pkg::CMD_GET: begin
				if (rx_head_q == rx_tail_q) begin
					status = utrg_pkg::STATUS_RX_EMPTY;
				end else begin
					rx_re     = accept;
					dsel      = utrg_pkg::DSEL_RX;
					rx_tail_d = ring_next(rx_tail_q);
				end
			end
			utrg_pkg::CMD_SEND: begin
				if (tx_head_q == tx_tail_q) begin
					status    = utrg_pkg::STATUS_TX_EMPTY;
					request_d = 1'b0;
				end else begin
					if (ring_next(tx_tail_q) == tx_head_q) begin
						request_d = 1'b0;
					end
					tx_re     = accept;
					dsel      = utrg_pkg::DSEL_TX;
					tx_tail_d = ring_next(tx_tail_q);
				end
			end
			utrg_pkg::CMD_TXDONE: begin
				if (tx_head_q == tx_tail_q) begin
					radio_d = 1'b0;
				end
			end
			utrg_pkg::CMD_RXBYTE: begin
				// A full ring drops its oldest byte to make room.
				if (ring_next(rx_head_q) == rx_tail_q) begin
					rx_tail_d = ring_next(rx_tail_q);
					overwrote = 1'b1;
				end
				rx_we     = accept;
				rx_head_d = ring_next(rx_head_q);
				if (req.data_byte == stop_char_q) begin
					stop_cnt_d = stop_cnt_q + 16'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign tx_waddr = tx_head_q;
	assign tx_raddr = tx_tail_q;
	assign rx_waddr = rx_head_q;
	assign rx_raddr = rx_tail_q;
	assign wdata    = req.data_byte;

	// Fill levels after this item, reported modulo sixteen.
	assign tx_fill_w = ring_fill(tx_head_d, tx_tail_d);
	assign rx_fill_w = ring_fill(rx_head_d, rx_tail_d);

	always_comb begin
		result.status       = status;
		result.dsel         = dsel;
		result.rx_overwrote = overwrote;
		result.radio_enable = radio_d;
		result.send_request = request_d;
		result.stop_count   = stop_cnt_d;
		result.tx_fill      = tx_fill_w[3:0];
		result.rx_fill      = rx_fill_w[3:0];
	end

	// Control state commits on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			radio_q    <= 1'b0;
			request_q  <= 1'b0;
			stop_cnt_q <= '0;
		end else if (accept) begin
			tx_head_q  <= tx_head_d;
			tx_tail_q  <= tx_tail_d;
			rx_head_q  <= rx_head_d;
			rx_tail_q  <= rx_tail_d;
			radio_q    <= radio_d;
			request_q  <= request_d;
			stop_cnt_q <= stop_cnt_d;
		end
	end

	// Stop character register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_char_q <= utrg_pkg::STOP_CHAR_RESET;
		end else if (cfg_we) begin
			stop_char_q <= cfg_wdata;
		end
	end

endmodule

/* rtl/uart_tx_rx_fifo_with_radio_gate_top.sv */
// Channel    Signals                          Transfer when
// request    req_valid, req_ready, req        req_valid && req_ready
// response   rsp_valid, rsp_ready, rsp        rsp_valid && rsp_ready
// config     cfg_we, cfg_wdata (stop char)    cfg_we
//
// A response is valid once the middle stage advances: pointers, flags and ring
// writes commit at the transfer edge, the ring read is registered at that same edge,
// and the byte joins the output register with that advance. A new request is taken
// every cycle while the response side keeps up. Reset clears pointers, flags, the stop
// counter and sets the stop character to ten; ring contents are not cleared. A stalled
// response holds the middle stage, which then holds back the request side.
module uart_tx_rx_fifo_with_radio_gate_top #(
	parameter int RING_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  utrg_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output utrg_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata
);

	localparam int PTR_W = $clog2(RING_DEPTH);

	logic               accept;
	logic               tx_we, tx_re, rx_we, rx_re;
	logic [PTR_W-1:0]   tx_waddr, tx_raddr, rx_waddr, rx_raddr;
	logic [7:0]         wdata, tx_rdata, rx_rdata;
	utrg_pkg::partial_t result;
	utrg_pkg::partial_t res_s1;
	logic               valid_s1;
	logic               advance;
	logic [7:0]         data_sel;
	logic               rsp_valid_q;
	utrg_pkg::rsp_t     rsp_q;

	utrg_ctrl #(
		.RING_DEPTH(RING_DEPTH),
		.PTR_W     (PTR_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.tx_we    (tx_we),
		.tx_waddr (tx_waddr),
		.tx_re    (tx_re),
		.tx_raddr (tx_raddr),
		.rx_we    (rx_we),
		.rx_waddr (rx_waddr),
		.rx_re    (rx_re),
		.rx_raddr (rx_raddr),
		.wdata    (wdata),
		.result   (result)
	);

	utrg_ring_ram #(
		.DEPTH (RING_DEPTH),
		.ADDR_W(PTR_W)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_waddr),
		.wdata(wdata),
		.re   (tx_re),
		.raddr(tx_raddr),
		.rdata(tx_rdata)
	);

	utrg_ring_ram #(
		.DEPTH (RING_DEPTH),
		.ADDR_W(PTR_W)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_waddr),
		.wdata(wdata),
		.re   (rx_re),
		.raddr(rx_raddr),
		.rdata(rx_rdata)
	);

	// Handshake: the middle stage moves on when the output register is free.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign accept    = req_valid && req_ready;

	// Middle stage waits for the ring read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= result;
		end
	end

	// Pick the returned byte.
	always_comb begin
		case (res_s1.dsel)
			utrg_pkg::DSEL_TX: data_sel = tx_rdata;
			utrg_pkg::DSEL_RX: data_sel = rx_rdata;
			default:           data_sel = 8'd0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.status       <= res_s1.status;
			rsp_q.data_out     <= data_sel;
			rsp_q.rx_overwrote <= res_s1.rx_overwrote;
			rsp_q.radio_enable <= res_s1.radio_enable;
			rsp_q.send_request <= res_s1.send_request;
			rsp_q.stop_count   <= res_s1.stop_count;
			rsp_q.tx_fill      <= res_s1.tx_fill;
			rsp_q.rx_fill      <= res_s1.rx_fill;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

	localparam int RING_DEPTH = 16;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int DRAIN_CYCLES = 6;
	localparam logic [2:0] CMD_TOP = '1;

	// Tracks both rings, the radio gate and the stop counter, and holds the
	// responses that the block still owes, oldest first.
	class uart_ring_scoreboard;
		utrg_pkg::rsp_t awaited_rsp[$];
		logic [7:0] tx_ring[RING_DEPTH];
		logic [7:0] rx_ring[RING_DEPTH];
		int unsigned tx_wr, tx_rd, rx_wr, rx_rd;
		bit radio_pwr;
		bit send_req;
		logic [15:0] stop_cnt;
		logic [7:0] stop_char;
		int mismatches;
		int responses_seen;
		int cmd_count[8];
		int overwrites;
		int rejects;

		function new();
			tx_wr = 0;
			tx_rd = 0;
			rx_wr = 0;
			rx_rd = 0;
			radio_pwr = 1'b0;
			send_req = 1'b0;
			stop_cnt = '0;
			stop_char = utrg_pkg::STOP_CHAR_RESET;
			mismatches = 0;
			responses_seen = 0;
			overwrites = 0;
			rejects = 0;
			foreach (cmd_count[i]) cmd_count[i] = 0;
		endfunction

		function int unsigned ring_next(int unsigned p);
			return (p + 1) % RING_DEPTH;
		endfunction

		function logic [3:0] ring_fill(int unsigned wr, int unsigned rd);
			int unsigned n;
			n = (wr + RING_DEPTH - rd) % RING_DEPTH;
			return n[3:0];
		endfunction

		function int pending();
			return awaited_rsp.size();
		endfunction

		// Applies one accepted request to the model state and queues the response.
		function void note_request(utrg_pkg::req_t r);
			utrg_pkg::rsp_t e;
			e = '0;
			cmd_count[r.cmd]++;
			case (r.cmd)
				utrg_pkg::CMD_PUT: begin
					if (ring_next(tx_wr) == tx_rd) begin
						e.status = utrg_pkg::STATUS_TX_FULL;
						rejects++;
					end else begin
						tx_ring[tx_wr] = r.data_byte;
						tx_wr = ring_next(tx_wr);
						radio_pwr = 1'b1;
						send_req = 1'b1;
					end
				end
				utrg_pkg::CMD_GET: begin
					if (rx_wr == rx_rd) begin
						e.status = utrg_pkg::STATUS_RX_EMPTY;
					end else begin
						e.data_out = rx_ring[rx_rd];
						rx_rd = ring_next(rx_rd);
					end
				end
				utrg_pkg::CMD_SEND: begin
					if (tx_wr == tx_rd) begin
						e.status = utrg_pkg::STATUS_TX_EMPTY;
						send_req = 1'b0;
					end else begin
						if (ring_next(tx_rd) == tx_wr)
							send_req = 1'b0;
						e.data_out = tx_ring[tx_rd];
						tx_rd = ring_next(tx_rd);
					end
				end
				utrg_pkg::CMD_TXDONE: begin
					if (tx_wr == tx_rd)
						radio_pwr = 1'b0;
				end
				utrg_pkg::CMD_RXBYTE: begin
					// A full receive ring drops its oldest byte to make room.
					if (ring_next(rx_wr) == rx_rd) begin
						rx_rd = ring_next(rx_rd);
						e.rx_overwrote = 1'b1;
						overwrites++;
					end
					rx_ring[rx_wr] = r.data_byte;
					if (r.data_byte == stop_char)
						stop_cnt = stop_cnt + 16'd1;
					rx_wr = ring_next(rx_wr);
				end
				default: begin
				end
			endcase
			e.radio_enable = radio_pwr;
			e.send_request = send_req;
			e.stop_count = stop_cnt;
			e.tx_fill = ring_fill(tx_wr, tx_rd);
			e.rx_fill = ring_fill(rx_wr, rx_rd);
			awaited_rsp.push_back(e);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%t mismatch: %s", $realtime, msg);
		endtask

		task field_check(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		// Compares one response transfer with the oldest expected response.
		task check_response(utrg_pkg::rsp_t got);
			utrg_pkg::rsp_t want;
			responses_seen++;
			if (awaited_rsp.size() == 0) begin
				report_mismatch($sformatf("response %0h with none outstanding", got));
			end else begin
				want = awaited_rsp.pop_front();
				field_check("status", 16'(got.status), 16'(want.status));
				field_check("data_out", 16'(got.data_out), 16'(want.data_out));
				field_check("rx_overwrote", 16'(got.rx_overwrote),
					16'(want.rx_overwrote));
				field_check("radio_enable", 16'(got.radio_enable),
					16'(want.radio_enable));
				field_check("send_request", 16'(got.send_request),
					16'(want.send_request));
				field_check("stop_count", got.stop_count, want.stop_count);
				field_check("tx_fill", 16'(got.tx_fill), 16'(want.tx_fill));
				field_check("rx_fill", 16'(got.rx_fill), 16'(want.rx_fill));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	utrg_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	utrg_pkg::rsp_t rsp;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	uart_ring_scoreboard sb;
	bit quiet;
	int cycles;
	int items_sent;

	uart_tx_rx_fifo_with_radio_gate_top #(
		.RING_DEPTH(RING_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// Cycle watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Response monitor.
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1)
			sb.check_response(rsp);
	end

	// Response side back-pressure in random bursts; always ready once quiet.
	initial begin
		rsp_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// Holds one request until its transfer; called at a rising edge.
	task automatic drive_item(logic [2:0] c, logic [7:0] b);
		utrg_pkg::req_t r;
		r.cmd = c;
		r.data_byte = b;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_ready !== 1'b1);
		sb.note_request(r);
		if (c <= utrg_pkg::CMD_RXBYTE)
			items_sent++;
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic issue(logic [2:0] c, logic [7:0] b);
		drive_item(c, b);
		maybe_idle();
	endtask

	// Register writes happen only with nothing in flight.
	task automatic write_stop_char(logic [7:0] v);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.stop_char = v;
	endtask

	function automatic logic [7:0] rx_payload();
		if ($urandom_range(0, 3) == 0)
			return sb.stop_char;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly bursts of one command so the rings fill, overflow and drain.
	task automatic run_random(int n);
		int target;
		int len;
		int mode;
		target = items_sent + n;
		while (items_sent < target) begin
			mode = $urandom_range(0, 9);
			len = $urandom_range(1, 20);
			repeat (len) begin
				case (mode)
					0, 1: issue(utrg_pkg::CMD_PUT, 8'($urandom_range(0, 255)));
					2, 3: issue(utrg_pkg::CMD_SEND, 8'($urandom_range(0, 255)));
					4, 5: issue(utrg_pkg::CMD_RXBYTE, rx_payload());
					6, 7: issue(utrg_pkg::CMD_GET, 8'($urandom_range(0, 255)));
					8: issue(3'($urandom_range(0, CMD_TOP)), rx_payload());
					default: issue(3'($urandom_range(utrg_pkg::CMD_PUT, utrg_pkg::CMD_RXBYTE)),
						rx_payload());
				endcase
			end
			if (mode == 2 || mode == 3)
				issue(utrg_pkg::CMD_TXDONE, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [7:0] stop_choices[4];
		clk = 1'b0;
		cycles = 0;
		items_sent = 0;
		quiet = 1'b0;
		sb = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty rings, both byte extremes, send and radio rules, undefined codes.
		issue(utrg_pkg::CMD_GET, 8'h00);
		issue(utrg_pkg::CMD_SEND, 8'h00);
		issue(utrg_pkg::CMD_TXDONE, 8'h00);
		issue(utrg_pkg::CMD_PUT, 8'h00);
		issue(utrg_pkg::CMD_PUT, 8'hFF);
		issue(utrg_pkg::CMD_TXDONE, 8'h00);
		issue(utrg_pkg::CMD_SEND, 8'h00);
		issue(utrg_pkg::CMD_SEND, 8'h00);
		issue(utrg_pkg::CMD_SEND, 8'h00);
		issue(utrg_pkg::CMD_TXDONE, 8'hFF);
		issue(utrg_pkg::CMD_RXBYTE, utrg_pkg::STOP_CHAR_RESET);
		issue(utrg_pkg::CMD_RXBYTE, 8'hFF);
		issue(utrg_pkg::CMD_RXBYTE, 8'h00);
		issue(utrg_pkg::CMD_GET, 8'hFF);
		issue(utrg_pkg::CMD_GET, 8'h00);
		issue(utrg_pkg::CMD_GET, 8'h00);
		issue(utrg_pkg::CMD_GET, 8'h00);
		issue(utrg_pkg::CMD_RXBYTE + 3'd1, 8'h55);
		issue(CMD_TOP - 3'd1, 8'hAA);
		issue(CMD_TOP, 8'hFF);
		issue(utrg_pkg::CMD_PUT, 8'hA5);
		issue(utrg_pkg::CMD_SEND, 8'hFF);
		issue(utrg_pkg::CMD_TXDONE, 8'h00);

		// Random phases, each with its own stop character.
		stop_choices[0] = 8'h00;
		stop_choices[1] = 8'hFF;
		stop_choices[2] = 8'($urandom_range(1, 254));
		stop_choices[3] = utrg_pkg::STOP_CHAR_RESET;
		foreach (stop_choices[i]) begin
			write_stop_char(stop_choices[i]);
			run_random(280);
		end

		// Last part without idling.
		quiet = 1'b1;
		run_random(150);

		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (put %0d, get %0d, send %0d, done %0d, rx %0d).",
			items_sent, sb.cmd_count[utrg_pkg::CMD_PUT], sb.cmd_count[utrg_pkg::CMD_GET],
			sb.cmd_count[utrg_pkg::CMD_SEND], sb.cmd_count[utrg_pkg::CMD_TXDONE],
			sb.cmd_count[utrg_pkg::CMD_RXBYTE]);
		$display("Checked %0d responses: %0d rejected puts, %0d rx overwrites, %0d mismatches.",
			sb.responses_seen, sb.rejects, sb.overwrites, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
